FILE: design/pidw_pkg.sv
// Shared constants, register codes and unit handshake types for the PID block.
// Used by every module of the design; depends on nothing.
`default_nettype none

package pidw_pkg;

	// Field and datapath widths.
	localparam int GAIN_W = 24;
	localparam int WREG_W = 31;
	localparam int VAL_W  = 32;
	localparam int ERR_W  = VAL_W + 1;
	localparam int DLT_W  = VAL_W + 2;
	localparam int SUM_W  = 48;
	localparam int FRAC_W = 16;
	localparam int MAG_W  = SUM_W;
	localparam int PROD_W = MAG_W + GAIN_W - FRAC_W;
	localparam int DIVD_W = WREG_W + FRAC_W;
	localparam int TERM_W = PROD_W + 2;
	localparam int IDX_W  = 3;

	// Default settle hold times in milliseconds.
	localparam int SMALL_HOLD_DEF = 100;
	localparam int BIG_HOLD_DEF   = 500;

	// Configuration register indexes.
	typedef enum logic [IDX_W-1:0] {
		REG_GAIN_P    = 3'd0,
		REG_GAIN_I    = 3'd1,
		REG_GAIN_D    = 3'd2,
		REG_SUM_RANGE = 3'd3,
		REG_INT_LIMIT = 3'd4,
		REG_SMALL_TOL = 3'd5,
		REG_BIG_TOL   = 3'd6,
		REG_RATE_TOL  = 3'd7
	} reg_idx_t;

	// Control into and status out of a serial arithmetic unit.
	typedef struct packed {
		logic start;
	} unit_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

endpackage

`default_nettype wire

FILE: design/pidw_smul.sv
// Bit-serial shift-and-add multiplier: magnitude times unsigned Q8.16 gain.
// Depends on pidw_pkg; takes one gain bit per cycle, most significant first.
`default_nettype none

module pidw_smul (
	input  logic                           clk,
	input  logic                           arst_n,
	input  pidw_pkg::unit_ctl_t            ctl,
	input  logic [pidw_pkg::MAG_W-1:0]     mag,
	input  logic [pidw_pkg::GAIN_W-1:0]    gain,
	output pidw_pkg::unit_sts_t            sts,
	output logic [pidw_pkg::PROD_W-1:0]    prod
);
	import pidw_pkg::*;

	localparam int ACC_W = MAG_W + GAIN_W;
	localparam int CNT_W = $clog2(GAIN_W + 1);

	logic [ACC_W-1:0]  acc_q;
	logic [MAG_W-1:0]  mag_q;
	logic [GAIN_W-1:0] gain_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [ACC_W-1:0]  addend;

	// The partial product for the current gain bit.
	assign addend = gain_q[GAIN_W-1] ? {{GAIN_W{1'b0}}, mag_q} : '0;

	// Sequencing: count the gain bits and flag completion for one cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(GAIN_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Accumulator: double and add once per gain bit.
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			acc_q  <= '0;
			mag_q  <= mag;
			gain_q <= gain;
		end else if (busy_q) begin
			acc_q  <= {acc_q[ACC_W-2:0], 1'b0} + addend;
			gain_q <= {gain_q[GAIN_W-2:0], 1'b0};
		end
	end

	// Drop the sixteen fraction bits of the gain, truncating toward zero.
	assign prod     = acc_q[ACC_W-1:FRAC_W];
	assign sts.busy = busy_q;
	assign sts.done = done_q;

endmodule

`default_nettype wire

FILE: design/pidw_sdiv.sv
// Restoring divider, one quotient bit per cycle, for the integral clamp bound.
// Depends on pidw_pkg; the divisor is the integral gain and must be nonzero.
`default_nettype none

module pidw_sdiv (
	input  logic                           clk,
	input  logic                           arst_n,
	input  pidw_pkg::unit_ctl_t            ctl,
	input  logic [pidw_pkg::DIVD_W-1:0]    dividend,
	input  logic [pidw_pkg::GAIN_W-1:0]    divisor,
	output pidw_pkg::unit_sts_t            sts,
	output logic [pidw_pkg::DIVD_W-1:0]    quot
);
	import pidw_pkg::*;

	localparam int CNT_W = $clog2(DIVD_W + 1);

	logic [GAIN_W-1:0] rem_q;
	logic [DIVD_W-1:0] dq_q;
	logic [GAIN_W-1:0] dv_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [GAIN_W:0]   trial;
	logic [GAIN_W:0]   diff;
	logic              ge;

	// Bring down the next dividend bit and try the subtraction.
	assign trial = {rem_q, dq_q[DIVD_W-1]};
	assign ge    = trial >= {1'b0, dv_q};
	assign diff  = trial - {1'b0, dv_q};

	// Sequencing: one step per dividend bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Partial remainder and shifting dividend/quotient register.
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= '0;
			dq_q  <= dividend;
			dv_q  <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[GAIN_W-1:0] : trial[GAIN_W-1:0];
			dq_q  <= {dq_q[DIVD_W-2:0], ge};
		end
	end

	assign quot     = dq_q;
	assign sts.busy = busy_q;
	assign sts.done = done_q;

endmodule

`default_nettype wire

FILE: design/pid_with_windup_and_settle_detect_top.sv
// Top level of the PID controller with integral anti-windup and settle detection.
// Depends on pidw_pkg, pidw_smul and pidw_sdiv.
//
//   channel | direction | handshake            | payload
//   in      | sink      | in_valid / in_stall  | measured, setpoint, now_ms,
//           |           |                      | check_arrival, clear_sum
//   out     | source    | out_valid / out_stall| drive, arrived
//   cfg     | sink      | cfg_we               | cfg_addr, cfg_wdata
//
// A result reaches the output register after its transaction is accepted and has gone through
// three passes of the shared bit-serial multiplier (proportional, derivative, integral), the
// sum update step and the final add. The next transaction can be accepted in the cycle after
// the result is loaded, so transactions do not overlap. The clamp divider runs alongside the
// first two passes. A new transaction is taken while the previous result still waits in the
// output register; if that result is still stalled when the next one is ready, the final
// step waits and in_stall stays high. Reset is asynchronous and active low.
`default_nettype none

module pid_with_windup_and_settle_detect_top #(
	parameter int SMALL_HOLD_MS = pidw_pkg::SMALL_HOLD_DEF,
	parameter int BIG_HOLD_MS   = pidw_pkg::BIG_HOLD_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [pidw_pkg::VAL_W-1:0]     measured,
	input  logic signed [pidw_pkg::VAL_W-1:0]     setpoint,
	input  logic [pidw_pkg::VAL_W-1:0]            now_ms,
	input  logic                                  check_arrival,
	input  logic                                  clear_sum,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [pidw_pkg::VAL_W-1:0]     drive,
	output logic                                  arrived,
	input  logic                                  cfg_we,
	input  logic [pidw_pkg::IDX_W-1:0]            cfg_addr,
	input  logic [pidw_pkg::WREG_W-1:0]           cfg_wdata
);
	import pidw_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_MULP = 6'b000010,
		S_MULD = 6'b000100,
		S_SUMS = 6'b001000,
		S_MULI = 6'b010000,
		S_FIN  = 6'b100000
	} state_t;

	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
	localparam logic signed [VAL_W-1:0] DRV_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic signed [VAL_W-1:0] DRV_MIN = {1'b1, {(VAL_W-1){1'b0}}};

	// Configuration registers.
	logic [GAIN_W-1:0] gain_p_q, gain_i_q, gain_d_q;
	logic [WREG_W-1:0] range_q, limit_q, small_tol_q, big_tol_q, rate_tol_q;

	// Controller state kept between transactions.
	state_t                    st_q;
	logic signed [ERR_W-1:0]   last_err_q;
	logic signed [SUM_W-1:0]   sum_q;
	logic                      first_q;
	logic [VAL_W-1:0]          shs_q, bhs_q;
	logic                      arrived_q;
	logic                      out_valid_q;
	logic signed [VAL_W-1:0]   drive_q;

	// Per-transaction working registers.
	logic signed [ERR_W-1:0]   err_q;
	logic [ERR_W-1:0]          aerr_q;
	logic signed [DLT_W-1:0]   dlt_q;
	logic [VAL_W-1:0]          now_q;
	logic                      chk_q;
	logic                      clamp_en_q;
	logic signed [TERM_W-1:0]  pterm_q, dterm_q, pd_q, iterm_q;
	logic [PROD_W-1:0]         adrv_q;

	// Serial units.
	unit_ctl_t          mul_ctl, div_ctl;
	unit_sts_t          mul_sts, div_sts;
	logic [MAG_W-1:0]   mul_mag;
	logic [GAIN_W-1:0]  mul_gain;
	logic [PROD_W-1:0]  mul_prod;
	logic [DIVD_W-1:0]  div_quot;

	logic                      in_acc;
	logic                      fin_load;
	logic                      clamp_en_c;
	logic signed [ERR_W-1:0]   err_c;
	logic [ERR_W-1:0]          aerr_c;
	logic signed [DLT_W-1:0]   dlt_c;
	logic [DLT_W-1:0]          adlt;

	logic signed [SUM_W:0]     s_wide;
	logic signed [SUM_W-1:0]   s_sat, s_clamp, s_rng, sum_new;
	logic [SUM_W-1:0]          s_mag, bound, sum_mag;
	logic                      mismatch;

	logic signed [TERM_W-1:0]  total;
	logic signed [VAL_W-1:0]   drive_c;
	logic                      in_small, in_big, hit_small, hit_big;

	assign in_stall = (st_q != S_IDLE);
	assign in_acc   = in_valid && (st_q == S_IDLE);
	assign fin_load = (st_q == S_FIN) && (!out_valid_q || !out_stall);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q    <= '0;
			gain_i_q    <= '0;
			gain_d_q    <= '0;
			range_q     <= '0;
			limit_q     <= WREG_W'(32768000);
			small_tol_q <= WREG_W'(65536);
			big_tol_q   <= WREG_W'(196608);
			rate_tol_q  <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_addr))
				REG_GAIN_P:    gain_p_q    <= cfg_wdata[GAIN_W-1:0];
				REG_GAIN_I:    gain_i_q    <= cfg_wdata[GAIN_W-1:0];
				REG_GAIN_D:    gain_d_q    <= cfg_wdata[GAIN_W-1:0];
				REG_SUM_RANGE: range_q     <= cfg_wdata;
				REG_INT_LIMIT: limit_q     <= cfg_wdata;
				REG_SMALL_TOL: small_tol_q <= cfg_wdata;
				REG_BIG_TOL:   big_tol_q   <= cfg_wdata;
				REG_RATE_TOL:  rate_tol_q  <= cfg_wdata;
			endcase
		end
	end

	// Error, its magnitude and the change since the last transaction.
	assign err_c      = $signed({setpoint[VAL_W-1], setpoint}) -
	                    $signed({measured[VAL_W-1], measured});
	assign aerr_c     = err_c[ERR_W-1] ? ERR_W'(-err_c) : ERR_W'(err_c);
	assign dlt_c      = first_q ? '0 :
	                    $signed({err_c[ERR_W-1], err_c}) -
	                    $signed({last_err_q[ERR_W-1], last_err_q});
	assign adlt       = dlt_q[DLT_W-1] ? DLT_W'(-dlt_q) : DLT_W'(dlt_q);
	assign clamp_en_c = (limit_q != '0) && (gain_i_q != '0);

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_ctl.start = 1'b0;
		mul_mag       = '0;
		mul_gain      = '0;
		priority if (in_acc) begin
			mul_ctl.start = 1'b1;
			mul_mag       = MAG_W'(aerr_c);
			mul_gain      = gain_p_q;
		end else if ((st_q == S_MULP) && mul_sts.done) begin
			mul_ctl.start = 1'b1;
			mul_mag       = MAG_W'(adlt);
			mul_gain      = gain_d_q;
		end else if ((st_q == S_SUMS) && !div_sts.busy) begin
			mul_ctl.start = 1'b1;
			mul_mag       = sum_mag;
			mul_gain      = gain_i_q;
		end else begin
			mul_ctl.start = 1'b0;
		end
	end

	assign div_ctl.start = in_acc && clamp_en_c;

	pidw_smul u_smul (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mul_ctl),
		.mag    (mul_mag),
		.gain   (mul_gain),
		.sts    (mul_sts),
		.prod   (mul_prod)
	);

	pidw_sdiv u_sdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend ({limit_q, {FRAC_W{1'b0}}}),
		.divisor  (gain_i_q),
		.sts      (div_sts),
		.quot     (div_quot)
	);

	// Error sum update: accumulate with saturation, clamp, then the clearing rules.
	assign s_wide  = $signed({sum_q[SUM_W-1], sum_q}) +
	                 $signed({{(SUM_W+1-ERR_W){err_q[ERR_W-1]}}, err_q});
	assign s_sat   = (s_wide[SUM_W] != s_wide[SUM_W-1]) ?
	                 (s_wide[SUM_W] ? SUM_MIN : SUM_MAX) : s_wide[SUM_W-1:0];
	assign s_mag   = s_sat[SUM_W-1] ? SUM_W'(-s_sat) : SUM_W'(s_sat);
	assign bound   = SUM_W'(div_quot);
	assign s_clamp = (clamp_en_q && (s_mag > bound)) ?
	                 (s_sat[SUM_W-1] ? -$signed(bound) : $signed(bound)) : s_sat;
	assign s_rng   = ((range_q != '0) && (aerr_q >= ERR_W'(range_q))) ? '0 : s_clamp;
	assign mismatch = (s_rng[SUM_W-1] != err_q[ERR_W-1]) ||
	                  ((s_rng == '0) != (err_q == '0));
	assign sum_new = (mismatch || (aerr_q <= ERR_W'(small_tol_q))) ? '0 : s_rng;
	assign sum_mag = sum_new[SUM_W-1] ? SUM_W'(-sum_new) : SUM_W'(sum_new);

	// Final sum of the three terms, saturated to the output width.
	assign total   = pd_q + iterm_q;
	assign drive_c = (total > TERM_W'(DRV_MAX)) ? DRV_MAX :
	                 (total < TERM_W'(DRV_MIN)) ? DRV_MIN : total[VAL_W-1:0];

	// Settle bands for this transaction.
	assign in_small  = chk_q && (aerr_q <= ERR_W'(small_tol_q)) &&
	                   (adrv_q <= PROD_W'(rate_tol_q));
	assign in_big    = chk_q && (aerr_q <= ERR_W'(big_tol_q)) &&
	                   (adrv_q <= PROD_W'(rate_tol_q));
	assign hit_small = in_small && ((now_q - shs_q) >= VAL_W'(SMALL_HOLD_MS));
	assign hit_big   = in_big && ((now_q - bhs_q) >= VAL_W'(BIG_HOLD_MS));

	// Sequencer and state kept across transactions.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			last_err_q  <= '0;
			sum_q       <= '0;
			first_q     <= 1'b1;
			shs_q       <= '0;
			bhs_q       <= '0;
			arrived_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				S_IDLE: begin
					if (in_acc) begin
						last_err_q <= err_c;
						sum_q      <= (clear_sum || first_q) ? '0 : sum_q;
						if (first_q) begin
							first_q <= 1'b0;
							shs_q   <= now_ms;
							bhs_q   <= now_ms;
						end
						st_q <= S_MULP;
					end
				end
				S_MULP: begin
					if (mul_sts.done) begin
						st_q <= S_MULD;
					end
				end
				S_MULD: begin
					if (mul_sts.done) begin
						st_q <= S_SUMS;
					end
				end
				S_SUMS: begin
					if (!div_sts.busy) begin
						sum_q <= sum_new;
						st_q  <= S_MULI;
					end
				end
				S_MULI: begin
					if (mul_sts.done) begin
						st_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (fin_load) begin
						arrived_q <= arrived_q | hit_small | hit_big;
						if (!in_small) begin
							shs_q <= now_q;
						end
						if (!in_big) begin
							bhs_q <= now_q;
						end
						st_q <= S_IDLE;
					end
				end
			endcase
		end
	end

	// Working registers of the transaction in progress.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			err_q      <= err_c;
			aerr_q     <= aerr_c;
			dlt_q      <= dlt_c;
			now_q      <= now_ms;
			chk_q      <= check_arrival;
			clamp_en_q <= clamp_en_c;
		end
		if ((st_q == S_MULP) && mul_sts.done) begin
			pterm_q <= err_q[ERR_W-1] ? -$signed(TERM_W'(mul_prod)) :
			           $signed(TERM_W'(mul_prod));
		end
		if ((st_q == S_MULD) && mul_sts.done) begin
			dterm_q <= dlt_q[DLT_W-1] ? -$signed(TERM_W'(mul_prod)) :
			           $signed(TERM_W'(mul_prod));
			adrv_q  <= mul_prod;
		end
		if ((st_q == S_SUMS) && !div_sts.busy) begin
			pd_q <= pterm_q + dterm_q;
		end
		if ((st_q == S_MULI) && mul_sts.done) begin
			iterm_q <= sum_q[SUM_W-1] ? -$signed(TERM_W'(mul_prod)) :
			           $signed(TERM_W'(mul_prod));
		end
		if (fin_load) begin
			drive_q <= drive_c;
		end
	end

	assign out_valid = out_valid_q;
	assign drive     = drive_q;
	assign arrived   = arrived_q;

`ifndef ASSERT_OFF
	// Both serial units are quiet whenever no transaction is in progress.
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_IDLE) |-> (!mul_sts.busy && !div_sts.busy))
		else $error("serial unit busy while idle");

	// A result appears only from the final step of a transaction.
	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(st_q == S_FIN))
		else $error("result raised outside the final step");

	// The arrived flag never falls once set.
	a_arrived_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arrived_q) |-> arrived_q)
		else $error("arrived flag cleared");
`endif

endmodule

`default_nettype wire

FILE: tb/pid_with_windup_and_settle_detect_top_tb.sv
// Self-checking testbench for the PID controller with anti-windup and settle detection.
// It predicts each drive value and arrival flag and compares them with the block's results.
// Depends on pidw_pkg and the block's top level.
`default_nettype none

module pid_with_windup_and_settle_detect_top_tb;
	import pidw_pkg::*;

	localparam int SMALL_MS = 100;
	localparam int BIG_MS   = 500;
	localparam int N_RAND   = 1100;

	typedef struct packed {
		logic signed [31:0] meas;
		logic signed [31:0] target;
		logic [31:0]        stamp;
		logic               chk;
		logic               clr;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] drv;
		logic               arr;
	} control_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [31:0] measured = '0;
	logic signed [31:0] setpoint = '0;
	logic [31:0] now_ms = '0;
	logic check_arrival = 1'b0;
	logic clear_sum = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] drive;
	logic arrived;
	logic cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_addr = '0;
	logic [WREG_W-1:0] cfg_wdata = '0;

	pid_with_windup_and_settle_detect_top dut (.*);

	// Predictor configuration and state.
	logic [23:0] kp, ki, kd;
	logic [30:0] range_w, limit_w, tol_small, tol_big, tol_rate;
	logic signed [63:0] prev_err, err_sum;
	logic fresh, settled_q;
	logic [31:0] small_t0, big_t0;

	sample_t pending[$];
	control_t expected_ctl[$];
	int errors = 0;
	int checked = 0;
	bit quiet = 1'b0;
	int drv_burst = 0;
	int mon_burst = 0;

	// Clock.
	initial begin
		forever #10 clk = ~clk;
	end

	// Gain times a Q16.16 value, rounded toward zero.
	function automatic logic signed [63:0] scale_q16(logic signed [63:0] v, logic [23:0] g);
		logic [63:0] m;
		logic [63:0] r;
		m = v < 0 ? -v : v;
		r = (m >> 16) * g + (((m & 64'hFFFF) * g) >> 16);
		return v < 0 ? -$signed(r) : $signed(r);
	endfunction

	function automatic int sign_of(logic signed [63:0] v);
		return (v > 0) - (v < 0);
	endfunction

	// Work out the result that one sample causes and advance the predictor.
	function automatic control_t pid_predict(sample_t s);
		logic signed [63:0] e, pt, dt, it, tot, acc;
		logic [63:0] ae, ad, bound;
		control_t c;
		if (s.clr) err_sum = 0;
		e = 64'(s.target) - 64'(s.meas);
		ae = e < 0 ? -e : e;
		if (fresh) begin
			fresh = 1'b0;
			prev_err = e;
			err_sum = 0;
			small_t0 = s.stamp;
			big_t0 = s.stamp;
		end
		pt = scale_q16(e, kp);
		dt = scale_q16(e - prev_err, kd);
		prev_err = e;
		if (range_w != 0 && ae >= 64'(range_w)) begin
			err_sum = 0;
		end else begin
			acc = err_sum + e;
			if (acc > 64'sh7FFF_FFFF_FFFF) acc = 64'sh7FFF_FFFF_FFFF;
			if (acc < -64'sh8000_0000_0000) acc = -64'sh8000_0000_0000;
			if (limit_w != 0 && ki != 0) begin
				bound = (64'(limit_w) << 16) / ki;
				if ((acc < 0 ? -acc : acc) > bound)
					acc = acc < 0 ? -$signed(bound) : $signed(bound);
			end
			err_sum = acc;
		end
		if (sign_of(err_sum) != sign_of(e) || ae <= 64'(tol_small)) err_sum = 0;
		it = scale_q16(err_sum, ki);
		ad = dt < 0 ? -dt : dt;
		if (s.chk && ae <= 64'(tol_small) && ad <= 64'(tol_rate)) begin
			if (32'(s.stamp - small_t0) >= SMALL_MS) settled_q = 1'b1;
		end else begin
			small_t0 = s.stamp;
		end
		if (s.chk && ae <= 64'(tol_big) && ad <= 64'(tol_rate)) begin
			if (32'(s.stamp - big_t0) >= BIG_MS) settled_q = 1'b1;
		end else begin
			big_t0 = s.stamp;
		end
		tot = pt + it + dt;
		if (tot > 64'sh7FFF_FFFF) tot = 64'sh7FFF_FFFF;
		if (tot < -64'sh8000_0000) tot = -64'sh8000_0000;
		c.drv = tot[31:0];
		c.arr = settled_q;
		return c;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("mismatch %s: got %h, expected %h (result %0d)", what, got, want, checked);
	endtask

	// Register write, only while the block is idle.
	task automatic write_reg(reg_idx_t idx, logic [30:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_GAIN_P:    kp = val[23:0];
			REG_GAIN_I:    ki = val[23:0];
			REG_GAIN_D:    kd = val[23:0];
			REG_SUM_RANGE: range_w = val;
			REG_INT_LIMIT: limit_w = val;
			REG_SMALL_TOL: tol_small = val;
			REG_BIG_TOL:   tol_big = val;
			default:       tol_rate = val;
		endcase
	endtask

	// Driver: presents pending samples, predicting each on acceptance.
	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			expected_ctl.push_back(pid_predict(pending.pop_front()));
		end
		if (drv_burst > 0) begin
			drv_burst--;
		end else if (!quiet && $urandom_range(0, 15) == 0) begin
			drv_burst = $urandom_range(1, 16);
		end
		if (in_valid && in_stall) begin
			// Hold the stalled transaction unchanged.
		end else if (pending.size() > 0 && drv_burst == 0) begin
			in_valid <= 1'b1;
			measured <= pending[0].meas;
			setpoint <= pending[0].target;
			now_ms <= pending[0].stamp;
			check_arrival <= pending[0].chk;
			clear_sum <= pending[0].clr;
		end else begin
			in_valid <= 1'b0;
		end
	end

	// Monitor: checks each accepted result and applies receiver stalls.
	always @(posedge clk) begin
		control_t w;
		if (out_valid && !out_stall) begin
			if (expected_ctl.size() == 0) begin
				report_mismatch("unexpected result", drive, 0);
			end else begin
				w = expected_ctl.pop_front();
				if (drive !== w.drv) report_mismatch("drive", drive, w.drv);
				if (arrived !== w.arr) report_mismatch("arrived", arrived, w.arr);
			end
			checked++;
		end
		if (mon_burst > 0) begin
			mon_burst--;
			out_stall <= 1'b1;
		end else if (!quiet && $urandom_range(0, 15) == 0) begin
			mon_burst = $urandom_range(1, 16);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	function automatic logic [31:0] rand_val();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom_range(0, 400000) - 200000;
			default: return $urandom;
		endcase
	endfunction

	// Queue a sample for the driver to present.
	task automatic add_sample(logic [31:0] m, logic [31:0] t, logic [31:0] st,
			logic ck, logic cl);
		sample_t s;
		s.meas = m;
		s.target = t;
		s.stamp = st;
		s.chk = ck;
		s.clr = cl;
		pending.push_back(s);
	endtask

	task automatic drain();
		while (pending.size() > 0 || expected_ctl.size() > 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	// A phase of settling runs and random samples.
	task automatic random_phase(int n);
		logic [31:0] clock_ms;
		logic [31:0] tgt;
		int k;
		clock_ms = $urandom;
		while (n > 0) begin
			tgt = rand_val();
			if ($urandom_range(0, 3) == 0) begin
				add_sample(rand_val(), rand_val(), $urandom, 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
				n--;
			end else begin
				// A run that converges on the target with advancing time.
				for (k = 0; k < 12 && n > 0; k++) begin
					clock_ms += $urandom_range(0, 120);
					add_sample(tgt + ($urandom_range(0, 2 * (262144 >> (k / 3))) -
						(262144 >> (k / 3))), tgt, clock_ms,
						$urandom_range(0, 7) != 0, $urandom_range(0, 15) == 0);
					n--;
				end
			end
		end
		drain();
	endtask

	initial begin
		kp = '0; ki = '0; kd = '0; range_w = '0; limit_w = 31'd32768000;
		tol_small = 31'd65536; tol_big = 31'd196608; tol_rate = '0;
		prev_err = 0; err_sum = 0; fresh = 1'b1; settled_q = 1'b0;
		small_t0 = '0; big_t0 = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: reset settings, first step, extremes and settle holds.
		add_sample(32'h0000_0000, 32'h0001_0000, 32'd0, 1'b1, 1'b0);
		add_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1);
		add_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'd5, 1'b1, 1'b0);
		drain();
		write_reg(REG_GAIN_P, 31'h00FF_FFFF);
		write_reg(REG_GAIN_I, 31'h0001_0000);
		write_reg(REG_GAIN_D, 31'h0000_8000);
		write_reg(REG_RATE_TOL, 31'h7FFF_FFFF);
		add_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'd10, 1'b1, 1'b0);
		add_sample(32'h0, 32'h0000_8000, 32'd50, 1'b1, 1'b0);
		add_sample(32'h0, 32'h0000_8000, 32'd150, 1'b1, 1'b0);
		add_sample(32'h0, 32'h0002_0000, 32'd700, 1'b1, 1'b0);
		add_sample(32'h0, 32'h0010_0000, 32'hFFFF_FFF0, 1'b1, 1'b0);
		add_sample(32'h0, 32'h0010_0000, 32'h0000_0060, 1'b1, 1'b0);
		add_sample(32'h0, 32'hFFF0_0000, 32'd200, 1'b1, 1'b1);
		drain();
		write_reg(REG_SUM_RANGE, 31'h0008_0000);
		write_reg(REG_INT_LIMIT, 31'h0000_0001);
		write_reg(REG_SMALL_TOL, 31'd0);
		write_reg(REG_BIG_TOL, 31'h7FFF_FFFF);
		add_sample(32'h0, 32'h0008_0000, 32'd300, 1'b0, 1'b0);
		add_sample(32'h0, 32'h0007_FFFF, 32'd301, 1'b0, 1'b0);
		add_sample(32'h0, 32'h0000_0001, 32'd302, 1'b1, 1'b0);
		add_sample(32'h0, 32'hFFFF_FFFF, 32'd303, 1'b1, 1'b0);
		drain();

		// Random phases under a range of settings, extremes included.
		write_reg(REG_SUM_RANGE, 31'd0);
		write_reg(REG_INT_LIMIT, 31'h7FFF_FFFF);
		write_reg(REG_GAIN_I, 31'h0000_0001);
		write_reg(REG_SMALL_TOL, 31'h0001_0000);
		write_reg(REG_BIG_TOL, 31'h0004_0000);
		write_reg(REG_RATE_TOL, 31'h0000_4000);
		random_phase(N_RAND / 4);
		write_reg(REG_GAIN_P, 31'($urandom));
		write_reg(REG_GAIN_I, 31'($urandom));
		write_reg(REG_GAIN_D, 31'($urandom));
		write_reg(REG_INT_LIMIT, 31'($urandom_range(0, 32'h0100_0000)));
		write_reg(REG_SUM_RANGE, 31'($urandom_range(0, 32'h0010_0000)));
		random_phase(N_RAND / 4);
		write_reg(REG_GAIN_P, 31'h0);
		write_reg(REG_GAIN_I, 31'h00FF_FFFF);
		write_reg(REG_GAIN_D, 31'h00FF_FFFF);
		write_reg(REG_INT_LIMIT, 31'd0);
		write_reg(REG_RATE_TOL, 31'h7FFF_FFFF);
		random_phase(N_RAND / 4);
		write_reg(REG_GAIN_P, 31'($urandom_range(0, 24'h03FFFF)));
		write_reg(REG_GAIN_I, 31'($urandom_range(0, 24'h00FFFF)));
		write_reg(REG_GAIN_D, 31'($urandom_range(0, 24'h03FFFF)));
		write_reg(REG_INT_LIMIT, 31'($urandom));
		quiet = 1'b1;
		random_phase(N_RAND / 4);

		$display("Checked %0d results over directed extremes and %0d random samples.",
			checked, N_RAND);
		$display("Settings covered gain extremes, clamp and range disabled and enabled.");
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#20000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire
